// ----- rtl/asve_pkg.sv -----
// Shared types and constants for the angle sensor velocity estimator.
`default_nettype none

package asve_pkg;

  localparam int unsigned ANG_W = 28;  // angle, tenths of a degree, Q.16
  localparam int unsigned NUM_W = 48;  // divider dividend / quotient
  localparam int unsigned DEN_W = 42;  // divider divisor
  localparam int unsigned ENT_W = 48;  // signed ring entry, Q.16
  localparam int unsigned SUM_W = 49;  // signed ring sum

  localparam logic [15:0]      ANGLE_SCALE = 16'd57614;
  localparam logic [ANG_W-1:0] ANGLE_HALF  = 28'h0008000;
  localparam logic [ANG_W-1:0] LOW_SEAM    = 28'd32768000;   // 500 << 16
  localparam logic [ANG_W-1:0] HIGH_SEAM   = 28'd203161600;  // 3100 << 16
  localparam logic [ANG_W-1:0] JUMP_LIMIT  = 28'd13107200;   // 200 << 16
  localparam logic [22:0]      VEL_GAIN    = 23'd5000000;

  localparam logic signed [2:0] DIR_MAX = 3'sd2;
  localparam logic signed [2:0] DIR_MIN = -3'sd2;

  localparam logic [NUM_W-1:0]  VEL_POS_LIM = 48'd32767;
  localparam logic [NUM_W-1:0]  VEL_NEG_LIM = 48'd32768;
  localparam logic signed [15:0] VEL_MAX    = 16'sh7FFF;
  localparam logic signed [15:0] VEL_MIN    = 16'sh8000;

  typedef struct packed {
    logic [11:0] raw_angle;
    logic        sample_ok;
    logic [23:0] elapsed_us;
  } asve_in_t;

  typedef struct packed {
    logic [11:0]        angle_tenths;
    logic               angle_published;
    logic signed [15:0] velocity;
    logic               velocity_updated;
  } asve_out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } asve_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } asve_div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/angle_sensor_velocity_estimator.sv -----
// Angle sensor velocity estimator: sequencer around one shared iterative divider.
// Sequence: an invalid sample goes from PREP straight to DONE, a skipped or large-jump
//   one passes through CHECK first; a velocity update adds one pass through the
//   bit-serial divider and one ring-sum pass over all RING_DEPTH entries.
// Throughput: one transaction at a time; the input stalls until the result is registered.
// Reset (rst_ni low, asynchronous): gear ratio 1, ring, angle, time and velocity cleared.
`default_nettype none

module angle_sensor_velocity_estimator
  import asve_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 3
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire asve_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output asve_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RING_DEPTH - 1);
  localparam logic [SUM_W-1:0] MEAN_HALF = SUM_W'(RING_DEPTH * 32768);
  // floor(x / RING_DEPTH) as (x * MEAN_RECIP) >> MEAN_SH, exact for any 32-bit x
  localparam int unsigned      MEAN_SH    = 32 + $clog2(RING_DEPTH);
  localparam logic [32:0]      MEAN_RECIP =
    33'(((68'd1 << MEAN_SH) + 68'(RING_DEPTH - 1)) / 68'(RING_DEPTH));

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHECK, S_MUL, S_DIVA_GO, S_DIVA_WAIT, S_STORE,
    S_SUM, S_SCALE, S_MEAN, S_DONE
  } state_e;

  state_e               state_q;
  asve_in_t             item_q;
  logic [7:0]           gear_q;
  logic [ANG_W-1:0]     ang_q;
  logic [ANG_W-1:0]     last_q;
  logic                 have_last_q;
  logic signed [2:0]    dir_q;
  logic [31:0]          time_q;
  logic [31:0]          dt_q;
  logic                 neg_q;
  logic [23:0]          mag_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic signed [ENT_W-1:0] ring_q [RING_DEPTH];
  logic [IDX_W-1:0]     ring_idx_q;
  logic [IDX_W-1:0]     sum_cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [67:0]          prod_q;
  logic signed [15:0]   vel_q;
  logic [11:0]          tenths_q;
  logic                 pub_q;
  logic                 upd_q;
  logic                 out_valid_q;
  asve_out_t            out_q;
  asve_div_req_t        div_req_q;
  asve_div_rsp_t        div_rsp;

  // combinational helpers
  logic [32:0]          tsum;
  logic                 seam;
  logic signed [2:0]    dir_nxt;
  logic                 skip_c;
  logic                 neg_c;
  logic [ANG_W-1:0]     mag_c;
  logic [ANG_W-1:0]     rnd_c;
  logic [7:0]           ratio_c;
  logic [9:0]           ratio3_c;
  logic [IDX_W-1:0]     idx_nxt;
  logic [SUM_W-1:0]     smag_c;
  logic [SUM_W-1:0]     rsum_c;
  logic [31:0]          tdiv_c;
  logic [NUM_W-1:0]     mean_c;
  logic                 out_free;

  always_comb begin
    tsum    = {1'b0, time_q} + 33'(item_q.elapsed_us);
    seam    = ((last_q < LOW_SEAM) && (ang_q > HIGH_SEAM)) ||
              ((ang_q < LOW_SEAM) && (last_q > HIGH_SEAM));
    neg_c   = (ang_q < last_q);
    mag_c   = neg_c ? (last_q - ang_q) : (ang_q - last_q);
    dir_nxt = dir_q;
    if (!neg_c) begin
      if (dir_q < DIR_MAX) dir_nxt = dir_q + 3'sd1;
    end else begin
      if (dir_q > DIR_MIN) dir_nxt = dir_q - 3'sd1;
    end
    // skipped: first sample, seam crossing, or direction not settled
    skip_c   = !have_last_q || seam || ((dir_nxt > DIR_MIN) && (dir_nxt < DIR_MAX));
    rnd_c    = ang_q + ANGLE_HALF;
    ratio_c  = (gear_q == 8'd0) ? 8'd1 : gear_q;
    ratio3_c = 10'(ratio_c) + {1'b0, ratio_c, 1'b0};
    idx_nxt  = (ring_idx_q == IDX_LAST) ? '0 : ring_idx_q + 1'b1;
    smag_c   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    // round half away from zero: (|sum| + depth * 2^15) / (depth * 2^16)
    rsum_c   = smag_c + MEAN_HALF;
    tdiv_c   = rsum_c[SUM_W-2:16];
    mean_c   = NUM_W'(prod_q[MEAN_SH +: 32]);
    out_free = !out_valid_q || !out_stall_i;
  end

  asve_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gear_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      ang_q       <= '0;
      last_q      <= '0;
      have_last_q <= 1'b0;
      dir_q       <= '0;
      time_q      <= '0;
      dt_q        <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
      ring_idx_q  <= '0;
      sum_cnt_q   <= '0;
      sum_q       <= '0;
      prod_q      <= '0;
      vel_q       <= '0;
      tenths_q    <= '0;
      pub_q       <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      div_req_q   <= '0;
    end else begin
      div_req_q.start <= (state_q == S_DIVA_GO);
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          time_q   <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
          ang_q    <= ANG_W'(item_q.raw_angle) * ANG_W'(ANGLE_SCALE);
          tenths_q <= '0;
          pub_q    <= 1'b0;
          upd_q    <= 1'b0;
          state_q  <= item_q.sample_ok ? S_CHECK : S_DONE;
        end
        S_CHECK: begin
          if (have_last_q && !seam) dir_q <= dir_nxt;
          have_last_q <= 1'b1;
          last_q      <= ang_q;
          time_q      <= '0;
          dt_q        <= (time_q == 32'd0) ? 32'd1 : time_q;
          neg_q       <= neg_c;
          mag_q       <= mag_c[23:0];
          if (skip_c) begin
            state_q <= S_DONE;
          end else begin
            pub_q    <= 1'b1;
            tenths_q <= rnd_c[ANG_W-1:16];
            state_q  <= (mag_c < JUMP_LIMIT) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          num_q   <= NUM_W'(mag_q) * NUM_W'(VEL_GAIN);
          den_q   <= DEN_W'(dt_q) * DEN_W'(ratio3_c);
          state_q <= S_DIVA_GO;
        end
        S_DIVA_GO: begin
          div_req_q.num   <= num_q + NUM_W'(den_q >> 1);
          div_req_q.den   <= den_q;
          state_q         <= S_DIVA_WAIT;
        end
        S_DIVA_WAIT: begin
          if (div_rsp.done) state_q <= S_STORE;
        end
        S_STORE: begin
          ring_q[idx_nxt] <= neg_q ? ENT_W'(NUM_W'(0) - div_rsp.quot)
                                   : ENT_W'(div_rsp.quot);
          ring_idx_q      <= idx_nxt;
          sum_q           <= '0;
          sum_cnt_q       <= '0;
          state_q         <= S_SUM;
        end
        S_SUM: begin
          sum_q     <= sum_q + SUM_W'(ring_q[sum_cnt_q]);
          sum_cnt_q <= sum_cnt_q + 1'b1;
          if (sum_cnt_q == IDX_LAST) state_q <= S_SCALE;
        end
        S_SCALE: begin
          prod_q  <= 68'(tdiv_c) * 68'(MEAN_RECIP);
          state_q <= S_MEAN;
        end
        S_MEAN: begin
          if (sum_q[SUM_W-1]) begin
            vel_q <= (mean_c > VEL_NEG_LIM) ? VEL_MIN
                                            : 16'(16'd0 - mean_c[15:0]);
          end else begin
            vel_q <= (mean_c > VEL_POS_LIM) ? VEL_MAX : 16'(mean_c[15:0]);
          end
          upd_q   <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_q.angle_tenths     <= tenths_q;
            out_q.angle_published  <= pub_q;
            out_q.velocity         <= vel_q;
            out_q.velocity_updated <= upd_q;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/asve_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module asve_divider
  import asve_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire asve_div_req_t req_i,
  output asve_div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem_q, rem_d, rem_sh;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    quo_d  = {quo_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.num;
        den_q  <= req_i.den;
        cnt_q  <= CNT_W'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the angle sensor velocity estimator: directed table, then random motion.
module testbench
  import asve_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS   = 3;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no transaction on any channel
  localparam int TAIL_CYCLES  = 200;   // longer than one velocity update
  localparam int SEGMENTS     = 6;
  localparam int SEG_SAMPLES  = 104;
  localparam int NUM_PROBES   = 19;

  typedef struct packed {
    logic [11:0] raw_angle;
    logic        sample_ok;
    logic [23:0] elapsed_us;
    logic [8:0]  repeats;
    logic        pinned;         // expected result written below, not predicted
    asve_out_t   pinned_result;
  } probe_row_t;

  localparam asve_out_t NO_READING = '0;

  // Rows marked pinned follow from reset alone; the rest go through the estimator model.
  probe_row_t probe_rows [NUM_PROBES] = '{
    '{12'd0,    1'b0, 24'd0,        9'd1,   1'b1, NO_READING},  // invalid right after reset
    '{12'd100,  1'b1, 24'd20000,    9'd1,   1'b1, NO_READING},  // first valid sample
    '{12'd110,  1'b1, 24'd20000,    9'd1,   1'b1, NO_READING},  // direction count only 1
    '{12'd120,  1'b1, 24'd20000,    9'd1,   1'b0, NO_READING},  // first velocity
    '{12'd4095, 1'b1, 24'd0,        9'd1,   1'b0, NO_READING},  // seam, low to high
    '{12'd4095, 1'b1, 24'd0,        9'd1,   1'b0, NO_READING},  // no motion, zero dt
    '{12'd4095, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},
    '{12'd0,    1'b1, 24'd20000,    9'd1,   1'b0, NO_READING},  // seam, high to low
    '{12'd3,    1'b1, 24'd1,        9'd1,   1'b0, NO_READING},  // positive clamp
    '{12'd2000, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},  // jump too large
    '{12'd1990, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},
    '{12'd1980, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},
    '{12'd1970, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},
    '{12'd1960, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},  // negative clamp
    '{12'd4095, 1'b0, 24'hFFFFFF,   9'd260, 1'b0, NO_READING},  // time accumulator saturates
    '{12'd1950, 1'b1, 24'hFFFFFF,   9'd1,   1'b0, NO_READING},
    '{12'd1940, 1'b1, 24'd1,        9'd1,   1'b0, NO_READING},
    '{12'd2047, 1'b0, 24'h800000,   9'd1,   1'b0, NO_READING},
    '{12'd2048, 1'b1, 24'h7FFFFF,   9'd1,   1'b0, NO_READING}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  asve_in_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  asve_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  asve_out_t readings_due [$];

  // Estimator model state
  logic [7:0]         est_gear;
  logic [31:0]        est_prev_angle;
  bit                 est_have_prev;
  int                 est_dir;
  logic [31:0]        est_elapsed;
  longint             est_ring [RING_SLOTS];
  int                 est_slot;
  logic signed [15:0] est_vel;

  // Random motion walker
  int walk_raw     = 2048;
  int walk_heading = 1;

  angle_sensor_velocity_estimator #(
    .RING_DEPTH(RING_SLOTS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic asve_out_t estimate_reading(asve_in_t s);
    asve_out_t   res;
    logic [31:0] ang;
    logic [31:0] mag;
    logic [32:0] t_sum;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] smag;
    longint      total;
    bit          skip;
    bit          neg;
    res = '0;
    t_sum = {1'b0, est_elapsed} + 33'(s.elapsed_us);
    est_elapsed = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
    if (s.sample_ok) begin
      ang = 32'(s.raw_angle) * 32'(ANGLE_SCALE);
      skip = !est_have_prev ||
             (est_prev_angle < 32'(LOW_SEAM) && ang > 32'(HIGH_SEAM)) ||
             (ang < 32'(LOW_SEAM) && est_prev_angle > 32'(HIGH_SEAM));
      if (!skip) begin
        if (ang >= est_prev_angle) begin
          if (est_dir < int'(DIR_MAX)) est_dir++;
        end else if (est_dir > int'(DIR_MIN)) begin
          est_dir--;
        end
        skip = est_dir > int'(DIR_MIN) && est_dir < int'(DIR_MAX);
      end
      if (!skip) begin
        neg = ang < est_prev_angle;
        mag = neg ? est_prev_angle - ang : ang - est_prev_angle;
        res.angle_published = 1'b1;
        res.angle_tenths = 12'((ang + 32'(ANGLE_HALF)) >> 16);
        if (mag < 32'(JUMP_LIMIT)) begin
          den = 64'd3 * (est_elapsed == 0 ? 64'd1 : 64'(est_elapsed)) *
                (est_gear == 0 ? 64'd1 : 64'(est_gear));
          q = (64'(mag) * 64'(VEL_GAIN) + den / 2) / den;
          est_slot = (est_slot + 1) % RING_SLOTS;
          est_ring[est_slot] = neg ? -longint'(q) : longint'(q);
          total = 0;
          foreach (est_ring[i]) total += est_ring[i];
          smag = total < 0 ? 64'(-total) : 64'(total);
          q = (smag + 64'(RING_SLOTS) * 64'd32768) / (64'(RING_SLOTS) * 64'd65536);
          if (total >= 0) est_vel = (q > 64'd32767) ? VEL_MAX : 16'(q);
          else est_vel = (q >= 64'd32768) ? VEL_MIN : 16'(-longint'(q));
          res.velocity_updated = 1'b1;
        end
      end
      est_have_prev  = 1'b1;
      est_prev_angle = ang;
      est_elapsed    = '0;
    end
    res.velocity = est_vel;
    return res;
  endfunction

  // Mostly steady rotation with random speed and timing; some reversals, dropouts and noise.
  function automatic asve_in_t next_motion_sample();
    asve_in_t s;
    int       k;
    int       step;
    k = $urandom_range(99);
    if (k < 6) walk_heading = -walk_heading;
    s.sample_ok = 1'b1;
    if (k < 8) begin
      s.raw_angle = 12'($urandom);
      s.sample_ok = 1'($urandom_range(1));
      if (s.sample_ok) walk_raw = s.raw_angle;
    end else if (k < 15) begin
      s.raw_angle = 12'($urandom);
      s.sample_ok = 1'b0;
    end else begin
      step = ($urandom_range(99) < 85) ? $urandom_range(40) : $urandom_range(41, 400);
      walk_raw = (walk_raw + walk_heading * step) & 12'hFFF;
      s.raw_angle = 12'(walk_raw);
    end
    k = $urandom_range(99);
    if (k < 4)       s.elapsed_us = 24'd0;
    else if (k < 20) s.elapsed_us = 24'($urandom_range(1, 200));
    else if (k < 80) s.elapsed_us = 24'($urandom_range(5000, 40000));
    else if (k < 97) s.elapsed_us = 24'($urandom);
    else             s.elapsed_us = 24'hFFFFFF;
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_result(asve_out_t got);
    asve_out_t want;
    if (readings_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = readings_due.pop_front();
    if (got.angle_tenths !== want.angle_tenths)
      report_mismatch($sformatf("angle_tenths %0d, expected %0d",
                                got.angle_tenths, want.angle_tenths));
    if (got.angle_published !== want.angle_published)
      report_mismatch($sformatf("angle_published %b, expected %b",
                                got.angle_published, want.angle_published));
    if (got.velocity !== want.velocity)
      report_mismatch($sformatf("velocity %0d, expected %0d", got.velocity, want.velocity));
    if (got.velocity_updated !== want.velocity_updated)
      report_mismatch($sformatf("velocity_updated %b, expected %b",
                                got.velocity_updated, want.velocity_updated));
  endtask

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic offer_sample(asve_in_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_gear(logic [7:0] ratio);
    cfg_valid <= 1'b1;
    cfg_data  <= ratio;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    est_gear = ratio;
  endtask

  // Result side: check, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    asve_in_t  s;
    asve_out_t want;
    est_gear       = 8'd1;
    est_prev_angle = '0;
    est_have_prev  = 1'b0;
    est_dir        = 0;
    est_elapsed    = '0;
    foreach (est_ring[i]) est_ring[i] = 0;
    est_slot       = 0;
    est_vel        = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 68;
    for (int r = 0; r < NUM_PROBES; r++) begin
      for (int k = 0; k < int'(probe_rows[r].repeats); k++) begin
        s.raw_angle  = probe_rows[r].raw_angle;
        s.sample_ok  = probe_rows[r].sample_ok;
        s.elapsed_us = probe_rows[r].elapsed_us;
        offer_sample(s);
        want = estimate_reading(s);
        readings_due.push_back(probe_rows[r].pinned ? probe_rows[r].pinned_result : want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: write_gear(8'd255);
        1: write_gear(8'd0);
        3: write_gear(8'd1);
        default: write_gear(8'($urandom_range(2, 254)));
      endcase
      if (seg < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 68;
      end else if (seg < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < SEG_SAMPLES; n++) begin
        s = next_motion_sample();
        offer_sample(s);
        readings_due.push_back(estimate_reading(s));
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
